### hdl/assert_macros.svh
// concurrent assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every sampled edge
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// consequent must hold whenever the antecedent holds
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

### hdl/mrrc_pkg.sv
package mrrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int unsigned EXC_BIT  = 7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_CRC = 2'd1,
    ST_EXCEPT  = 2'd2,
    ST_UNKNOWN = 2'd3
  } mrrc_status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } mrrc_in_t;

  typedef struct packed {
    logic [7:0]   unit_id;
    logic [7:0]   function_code;
    mrrc_status_e status;
    logic [7:0]   exception_code;
    logic [8:0]   frame_length;
  } mrrc_out_t;

  // crc-16/modbus, one byte, lsb first
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic is_read(logic [7:0] fc);
    return (fc >= 8'd1) && (fc <= 8'd4);
  endfunction

  function automatic logic is_write(logic [7:0] fc);
    return (fc == 8'd5) || (fc == 8'd6) || (fc == 8'd15) || (fc == 8'd16);
  endfunction

endpackage

### hdl/modbus_rtu_response_checker.sv
// latency: a result appears on out_valid_o the cycle after the last frame byte is accepted
// throughput: one byte per cycle while in_ready_o is high; the crc byte update is unrolled and combinational
// the input is ready whenever the result register is empty or being drained this cycle
// reset (rst_ni low, asynchronous): no frame active, crc at 0xffff, result register empty
module modbus_rtu_response_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mrrc_pkg::mrrc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mrrc_pkg::mrrc_out_t out_data_o
);
  import mrrc_pkg::*;

  // byte positions inside a frame
  localparam logic [8:0] IDX_FUNC  = 9'd1;
  localparam logic [8:0] IDX_BYTE2 = 9'd2;
  localparam logic [8:0] LEN_EXC   = 9'd5;
  localparam logic [8:0] LEN_WRITE = 9'd8;
  localparam logic [8:0] LEN_UNK   = 9'd2;

  // frame tracking state
  logic [8:0]  byte_index_q, byte_index_d;
  logic [8:0]  exp_len_q, exp_len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  unit_q, unit_d;
  logic [7:0]  func_q, func_d;
  logic [7:0]  byte2_q, byte2_d;
  logic [7:0]  crc_low_q, crc_low_d;
  logic        active_q, active_d;

  // result register
  logic        out_valid_q, out_valid_d;
  mrrc_out_t   out_q, out_d;

  logic        in_acc;
  logic        res_valid;
  mrrc_out_t   res;
  logic [8:0]  exp_w;
  logic [7:0]  b;
  logic [15:0] got_crc;

  // accept a new byte as long as the result register can take a result
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign b          = in_data_i.rx_byte;
  assign got_crc    = {b, crc_low_q};

  // frame parsing, one accepted byte per pass
  always_comb begin
    byte_index_d = byte_index_q;
    exp_len_d    = exp_len_q;
    crc_d        = crc_q;
    unit_d       = unit_q;
    func_d       = func_q;
    byte2_d      = byte2_q;
    crc_low_d    = crc_low_q;
    active_d     = active_q;
    res_valid    = 1'b0;
    res          = '{unit_id: unit_q, function_code: func_q, status: ST_OK,
                     exception_code: 8'h00, frame_length: exp_len_q};
    exp_w        = exp_len_q;

    if (in_acc) begin
      if (in_data_i.frame_start) begin
        // a start drops any partial frame
        active_d     = 1'b1;
        unit_d       = b;
        func_d       = 8'h00;
        byte2_d      = 8'h00;
        crc_low_d    = 8'h00;
        exp_len_d    = 9'd0;
        crc_d        = crc_feed(CRC_INIT, b);
        byte_index_d = IDX_FUNC;
      end else if (active_q) begin
        if (byte_index_q == IDX_FUNC) begin
          func_d       = b;
          crc_d        = crc_feed(crc_q, b);
          byte_index_d = IDX_BYTE2;
          if (b[EXC_BIT]) begin
            exp_len_d = LEN_EXC;
          end else if (is_read(b)) begin
            // length follows from the byte count in byte 2
            exp_len_d = 9'd0;
          end else if (is_write(b)) begin
            exp_len_d = LEN_WRITE;
          end else begin
            // unknown function code: report now, then ignore until next start
            active_d           = 1'b0;
            res_valid          = 1'b1;
            res.function_code  = b;
            res.status         = ST_UNKNOWN;
            res.exception_code = 8'h00;
            res.frame_length   = LEN_UNK;
          end
        end else begin
          if (byte_index_q == IDX_BYTE2) begin
            byte2_d = b;
            if (!func_q[EXC_BIT] && is_read(func_q)) begin
              exp_w = LEN_EXC + {1'b0, b};
            end
          end
          exp_len_d = exp_w;

          if (exp_w < LEN_EXC) begin
            active_d = 1'b0;
          end else if (byte_index_q < exp_w - 9'd2) begin
            // payload byte, still covered by the crc
            crc_d        = crc_feed(crc_q, b);
            byte_index_d = byte_index_q + 9'd1;
          end else if (byte_index_q == exp_w - 9'd2) begin
            crc_low_d    = b;
            byte_index_d = byte_index_q + 9'd1;
          end else begin
            // crc high byte: close the frame
            active_d           = 1'b0;
            byte_index_d       = byte_index_q + 9'd1;
            res_valid          = 1'b1;
            res.exception_code = func_q[EXC_BIT] ? byte2_q : 8'h00;
            res.frame_length   = exp_w;
            if (got_crc != crc_q) begin
              res.status = ST_BAD_CRC;
            end else if (func_q[EXC_BIT]) begin
              res.status = ST_EXCEPT;
            end else begin
              res.status = ST_OK;
            end
          end
        end
      end
    end
  end

  // result register: load on a new result, clear when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      exp_len_q    <= '0;
      crc_q        <= CRC_INIT;
      unit_q       <= '0;
      func_q       <= '0;
      byte2_q      <= '0;
      crc_low_q    <= '0;
      active_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_index_q <= byte_index_d;
      exp_len_q    <= exp_len_d;
      crc_q        <= crc_d;
      unit_q       <= unit_d;
      func_q       <= func_d;
      byte2_q      <= byte2_d;
      crc_low_q    <= crc_low_d;
      active_q     <= active_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "assert_macros.svh"

  // an unknown code is reported with its fixed length and no exception byte
  `ASSERT_IMPLIES(a_unknown_fields, out_valid_o && (out_data_o.status == ST_UNKNOWN), (out_data_o.frame_length == LEN_UNK) && (out_data_o.exception_code == 8'h00))
  // only exception responses carry an exception byte
  `ASSERT_IMPLIES(a_exc_only_on_exc, out_valid_o && !out_data_o.function_code[EXC_BIT], out_data_o.exception_code == 8'h00)
  // past the byte count the position never runs beyond the frame
  `ASSERT_IMPLIES(a_index_in_frame, active_q && (byte_index_q > IDX_BYTE2), (exp_len_q >= LEN_EXC) && (byte_index_q < exp_len_q))
  // a new result is never loaded over one that is still waiting
  `ASSERT_ALWAYS(a_no_overwrite, !(res_valid && out_valid_q && !out_ready_i))

endmodule

### tb/modbus_rtu_response_checker_tb.sv
module modbus_rtu_response_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrrc_pkg::*;

  // how the table row picks its byte: as written, or from the crc of the frame so far
  typedef enum logic [1:0] {
    CS_LIT,
    CS_LO,
    CS_HI,
    CS_HI_BAD
  } crc_sel_e;

  // frame class by function code
  typedef enum logic [1:0] {
    FK_EXC,
    FK_READ,
    FK_WRITE,
    FK_OTHER
  } fc_class_e;

  typedef struct {
    logic [7:0] rx;
    logic       start;
    crc_sel_e   sel;
    bit         typed;
    mrrc_out_t  want;
  } dir_row_t;

  localparam mrrc_out_t NO_RES = '0;

  // directed frames; the typed results are the ones obvious from the frame itself
  dir_row_t dir_tab [29] = '{
    // byte while idle right after reset, ignored
    '{8'hFF, 1'b0, CS_LIT, 1'b0, NO_RES},
    // unknown function code, then a stray byte that is ignored
    '{8'h00, 1'b1, CS_LIT, 1'b0, NO_RES},
    '{8'h07, 1'b0, CS_LIT, 1'b1, '{8'h00, 8'h07, ST_UNKNOWN, 8'h00, 9'd2}},
    '{8'h55, 1'b0, CS_LIT, 1'b0, NO_RES},
    // exception response with good crc
    '{8'hFF, 1'b1, CS_LIT, 1'b0, NO_RES},
    '{8'h83, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'h02, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'h00, 1'b0, CS_LO,  1'b0, NO_RES},
    '{8'h00, 1'b0, CS_HI,  1'b1, '{8'hFF, 8'h83, ST_EXCEPT, 8'h02, 9'd5}},
    // exception response with bad crc, exception code still reported
    '{8'h11, 1'b1, CS_LIT, 1'b0, NO_RES},
    '{8'h81, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'hFF, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'h00, 1'b0, CS_LO,  1'b0, NO_RES},
    '{8'h00, 1'b0, CS_HI_BAD, 1'b1, '{8'h11, 8'h81, ST_BAD_CRC, 8'hFF, 9'd5}},
    // read frame cut short by a new start
    '{8'h22, 1'b1, CS_LIT, 1'b0, NO_RES},
    '{8'h03, 1'b0, CS_LIT, 1'b0, NO_RES},
    // read with byte count zero
    '{8'h01, 1'b1, CS_LIT, 1'b0, NO_RES},
    '{8'h04, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'h00, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'h00, 1'b0, CS_LO,  1'b0, NO_RES},
    '{8'h00, 1'b0, CS_HI,  1'b1, '{8'h01, 8'h04, ST_OK, 8'h00, 9'd5}},
    // write multiple registers echo, checked by the predictor
    '{8'hA5, 1'b1, CS_LIT, 1'b0, NO_RES},
    '{8'h10, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'h00, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'hFF, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'h7E, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'h81, 1'b0, CS_LIT, 1'b0, NO_RES},
    '{8'h00, 1'b0, CS_LO,  1'b0, NO_RES},
    '{8'h00, 1'b0, CS_HI,  1'b0, NO_RES}
  };

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  mrrc_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mrrc_out_t out_data;

  // dut outputs as sampled at the falling edge before each rising edge
  logic      in_ready_s  = 1'b0;
  logic      out_valid_s = 1'b0;
  mrrc_out_t out_data_s  = '0;

  // predictor state
  logic [8:0]  pr_pos    = '0;
  logic [8:0]  pr_len    = '0;
  logic [15:0] pr_crc    = CRC_INIT;
  logic [7:0]  pr_unit   = '0;
  logic [7:0]  pr_func   = '0;
  logic [7:0]  pr_b2     = '0;
  logic [7:0]  pr_crc_lo = '0;
  bit          pr_open   = 1'b0;

  mrrc_out_t   frame_results_q [$];

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 75;
  bit          pressure_go   = 1'b0;
  bit          pressure_done = 1'b0;

  int unsigned err_cnt     = 0;
  int unsigned bytes_sent  = 0;
  int unsigned rand_bytes  = 0;
  int unsigned frames_sent = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  modbus_rtu_response_checker u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // sample at the falling edge so decisions at the rising edge see settled values
  always @(negedge clk_i) begin
    in_ready_s  = in_ready;
    out_valid_s = out_valid;
    out_data_s  = out_data;
  end

  // crc-16/modbus over one byte, lsb first
  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {8'h00, d};
    repeat (8) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic fc_class_e fc_kind(logic [7:0] fc);
    if (fc[EXC_BIT]) return FK_EXC;
    if (fc >= 8'd1 && fc <= 8'd4) return FK_READ;
    if (fc == 8'd5 || fc == 8'd6 || fc == 8'd15 || fc == 8'd16) return FK_WRITE;
    return FK_OTHER;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
  endtask

  // frame tracking for one accepted byte; fired marks a result at the end of a frame
  task automatic predict_byte(input logic [7:0] b, input logic start, output bit fired,
                              output mrrc_out_t res);
    logic [15:0] got_crc;
    fired = 1'b0;
    res   = '0;
    if (start) begin
      // a start always opens a fresh frame, any partial one is dropped
      pr_open   = 1'b1;
      pr_unit   = b;
      pr_func   = '0;
      pr_b2     = '0;
      pr_crc_lo = '0;
      pr_len    = '0;
      pr_crc    = crc16_step(CRC_INIT, b);
      pr_pos    = 9'd1;
    end else if (pr_open) begin
      if (pr_pos == 9'd1) begin
        pr_func = b;
        pr_crc  = crc16_step(pr_crc, b);
        pr_pos  = 9'd2;
        case (fc_kind(b))
          FK_EXC:   pr_len = 9'd5;
          FK_READ:  pr_len = 9'd0;
          FK_WRITE: pr_len = 9'd8;
          default: begin
            // unknown code: report at once and go idle
            pr_open = 1'b0;
            fired   = 1'b1;
            res     = '{pr_unit, b, ST_UNKNOWN, 8'h00, 9'd2};
          end
        endcase
      end else begin
        if (pr_pos == 9'd2) begin
          pr_b2 = b;
          if (fc_kind(pr_func) == FK_READ) pr_len = 9'd5 + {1'b0, b};
        end
        if (pr_pos < pr_len - 9'd2) begin
          pr_crc = crc16_step(pr_crc, b);
          pr_pos = pr_pos + 9'd1;
        end else if (pr_pos == pr_len - 9'd2) begin
          pr_crc_lo = b;
          pr_pos    = pr_pos + 9'd1;
        end else begin
          // last byte: crc high, compare against the running crc
          got_crc            = {b, pr_crc_lo};
          res.unit_id        = pr_unit;
          res.function_code  = pr_func;
          res.exception_code = pr_func[EXC_BIT] ? pr_b2 : 8'h00;
          res.frame_length   = pr_len;
          if (got_crc != pr_crc) res.status = ST_BAD_CRC;
          else if (pr_func[EXC_BIT]) res.status = ST_EXCEPT;
          else res.status = ST_OK;
          pr_open = 1'b0;
          pr_pos  = pr_pos + 9'd1;
          fired   = 1'b1;
        end
      end
    end
  endtask

  // offer one byte, hold it until accepted, then record what it should produce
  task automatic send_item(input logic [7:0] b, input logic start, input bit typed,
                           input mrrc_out_t typed_res);
    bit        fired;
    mrrc_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, frame_start: start};
    do @(posedge clk_i); while (!in_ready_s);
    predict_byte(b, start, fired, pred);
    if (typed) frame_results_q.push_back(typed_res);
    else if (fired) frame_results_q.push_back(pred);
    bytes_sent++;
  endtask

  // one well-formed response with random content, sometimes corrupted or cut short
  task automatic send_random_frame(input bit max_read);
    logic [7:0]  body [$];
    logic [7:0]  fc;
    logic [15:0] c;
    int unsigned pick, cnt, keep, r;
    bit          with_crc, cut;
    pick     = max_read ? 0 : $urandom_range(99);
    with_crc = 1'b1;
    cut      = 1'b0;
    body.push_back(8'($urandom));
    if (pick < 35) begin
      // read: mostly short payloads, now and then up to the full 255 bytes
      fc = 8'($urandom_range(1, 4));
      r  = $urandom_range(99);
      if (max_read) cnt = 255;
      else if (r < 70) cnt = $urandom_range(0, 6);
      else if (r < 92) cnt = $urandom_range(0, 40);
      else if (r < 98) cnt = $urandom_range(0, 255);
      else cnt = 255;
      body.push_back(fc);
      body.push_back(cnt[7:0]);
      repeat (cnt) body.push_back(8'($urandom));
    end else if (pick < 60) begin
      case ($urandom_range(3))
        0:       fc = 8'd5;
        1:       fc = 8'd6;
        2:       fc = 8'd15;
        default: fc = 8'd16;
      endcase
      body.push_back(fc);
      repeat (4) body.push_back(8'($urandom));
    end else if (pick < 82) begin
      fc = 8'h80 | 8'($urandom);
      body.push_back(fc);
      body.push_back(8'($urandom));
    end else begin
      do fc = 8'($urandom_range(0, 127)); while (fc_kind(fc) != FK_OTHER);
      body.push_back(fc);
      with_crc = 1'b0;
    end
    if (with_crc) begin
      c = CRC_INIT;
      foreach (body[i]) c = crc16_step(c, body[i]);
      r = $urandom_range(99);
      if (r < 10) c = c ^ 16'(1 << $urandom_range(15));
      else if (r < 15) c = 16'($urandom);
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
    end
    // broken frame: the next start drops it
    if ($urandom_range(99) < 8) begin
      cut  = 1'b1;
      keep = $urandom_range(1, body.size() - 1);
      while (body.size() > keep) void'(body.pop_back());
    end
    foreach (body[i]) send_item(body[i], i == 0, 1'b0, NO_RES);
    rand_bytes += body.size();
    frames_sent++;
    // stray bytes between frames are ignored by the block
    if (!cut && $urandom_range(99) < 25) begin
      repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0, 1'b0, NO_RES);
    end
  endtask

  // result side: random back-pressure plus one long hold-off to fill the block
  initial begin : result_sink
    int unsigned held;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pressure_go && !pressure_done) begin
        pressure_done = 1'b1;
        for (held = 0; held < 400; held++) begin
          out_ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare every accepted result with the oldest expected one
  always @(posedge clk_i) begin : result_check
    mrrc_out_t want;
    if (rst_ni && out_valid_s && out_ready) begin
      if (frame_results_q.size() == 0) begin
        report_mismatch("result with nothing expected, function_code",
                        out_data_s.function_code, 0);
      end else begin
        want = frame_results_q.pop_front();
        status_seen[want.status]++;
        if (out_data_s.unit_id !== want.unit_id)
          report_mismatch("unit_id", out_data_s.unit_id, want.unit_id);
        if (out_data_s.function_code !== want.function_code)
          report_mismatch("function_code", out_data_s.function_code, want.function_code);
        if (out_data_s.status !== want.status)
          report_mismatch("status", out_data_s.status, want.status);
        if (out_data_s.exception_code !== want.exception_code)
          report_mismatch("exception_code", out_data_s.exception_code, want.exception_code);
        if (out_data_s.frame_length !== want.frame_length)
          report_mismatch("frame_length", out_data_s.frame_length, want.frame_length);
      end
    end
  end

  // stimulus: directed table, then three idling phases of random frames
  initial begin : stimulus
    dir_row_t    row;
    logic [15:0] tx_crc;
    logic [7:0]  byte_v;
    int unsigned phase;
    tx_crc = CRC_INIT;
    phase  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part; crc rows are filled from the bytes sent since the last start
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      case (row.sel)
        CS_LIT: begin
          tx_crc = crc16_step(row.start ? CRC_INIT : tx_crc, row.rx);
          byte_v = row.rx;
        end
        CS_LO:     byte_v = tx_crc[7:0];
        CS_HI:     byte_v = tx_crc[15:8];
        default:   byte_v = ~tx_crc[15:8];
      endcase
      send_item(byte_v, row.start, row.typed, row.want);
    end

    // random part
    while (rand_bytes < 1000) begin
      if (phase == 0 && rand_bytes >= 333) begin
        // sender slow, receiver eager
        send_idle_pct = 75;
        recv_idle_pct = 17;
        phase = 1;
      end
      if (phase == 1 && rand_bytes >= 666) begin
        // full rate both ways, with one long stall on the result side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pressure_go   = 1'b1;
        phase = 2;
      end
      send_random_frame(frames_sent == 3);
    end
    in_valid <= 1'b0;

    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d bytes, %0d random frames (some cut short, some with bad crc)",
             bytes_sent, frames_sent);
    $display("results checked: %0d ok, %0d bad crc, %0d exception, %0d unknown code",
             status_seen[ST_OK], status_seen[ST_BAD_CRC], status_seen[ST_EXCEPT],
             status_seen[ST_UNKNOWN]);
    if (err_cnt == 0 && frame_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results outstanding", frame_results_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
